// ===== src/htwd_pkg.sv =====
// Shared types and constants for the Huffman tree-walk decoder.
package htwd_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int TAIL_W = 3;
  localparam int ENT_W  = 2 * IDX_W;

  localparam logic [IDX_W-1:0] ROOT_NODE = 9'd511;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // write a node entry from the input word
    logic start;     // latch a data byte and its bit count
    logic first_rd;  // issue the table read for the first bit
    logic step;      // consume a read result, issue the next read
    logic finish;    // flush the held symbol, close out the byte
  } htwd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic leaf;
    logic last_bit;
    logic pend_valid;
    logic out_free;
  } htwd_sts_t;

endpackage

// ===== src/htwd_in_if.sv =====
// Input channel: valid/ready handshake carrying one load or data word.
interface htwd_in_if
  import htwd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  node_index;
  logic [IDX_W-1:0]  left_child;
  logic [IDX_W-1:0]  right_child;
  logic [BYTE_W-1:0] data_byte;

  modport source (
    output valid, kind, node_index, left_child, right_child, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, left_child, right_child, data_byte,
    output ready
  );
endinterface

// ===== src/htwd_out_if.sv =====
// Output channel: valid/ready handshake carrying one decoded symbol word.
interface htwd_out_if
  import htwd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_of_run;

  modport source (
    output valid, symbol, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, symbol, last_of_run,
    output ready
  );
endinterface

// ===== src/htwd_ctrl.sv =====
// Sequencer for the tree walk: accepts words and steps the datapath bit by bit.
module htwd_ctrl
  import htwd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  input  htwd_sts_t         sts_i,
  output htwd_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       stall;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // A second leaf cannot retire the held symbol while the output is busy.
  assign stall      = sts_i.leaf && sts_i.pend_valid && !sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (in_kind_i == KIND_DATA || in_kind_i == KIND_FINAL) begin
            cmd_o.start = 1'b1;
            state_d     = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd_o.first_rd = 1'b1;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (!stall) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_bit) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/htwd_dpath.sv =====
// Node table, walk registers, held symbol and output register.
module htwd_dpath
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htwd_cmd_t         cmd_i,
  output htwd_sts_t         sts_o,
  input  logic              cfg_we_i,
  input  logic [TAIL_W-1:0] cfg_wdata_i,
  input  logic [KIND_W-1:0] in_kind_i,
  input  logic [IDX_W-1:0]  in_node_index_i,
  input  logic [IDX_W-1:0]  in_left_child_i,
  input  logic [IDX_W-1:0]  in_right_child_i,
  input  logic [BYTE_W-1:0] in_data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SYM_W-1:0]  out_symbol_o,
  output logic              out_last_of_run_o
);

  localparam int  AW      = $clog2(NODE_COUNT);
  localparam bit  ROOT_IN = (NODE_COUNT > 511);

  logic [ENT_W-1:0]  node_mem [NODE_COUNT];

  logic [TAIL_W-1:0] tail_q;
  logic [BYTE_W-1:0] byte_q;
  logic [2:0]        cnt_q;
  logic              final_q;
  logic [ENT_W-1:0]  ent_q;
  logic [ENT_W-1:0]  root_q;
  logic [IDX_W-1:0]  cur_q;
  logic              at_root_q;
  logic [IDX_W-1:0]  next_q;
  logic [ENT_W-1:0]  rd_q;
  logic              oob_q;
  logic              pend_valid_q;
  logic [SYM_W-1:0]  pend_sym_q;
  logic              out_valid_q;
  logic [SYM_W-1:0]  out_sym_q;
  logic              out_last_q;

  logic [ENT_W-1:0]  root_ent, eff_ent, new_ent, rd_ent, load_ent;
  logic [2:0]        cnt_dec, start_idx;
  logic              rd_bit, rd_en, leaf, out_free, load_ok;
  logic [IDX_W-1:0]  rd_idx;
  logic [SYM_W-1:0]  leaf_sym;
  logic              push_mid, push_end;

  assign root_ent  = ROOT_IN ? root_q : '0;
  assign eff_ent   = at_root_q ? root_ent : ent_q;
  // Out-of-range indices and all-zero entries are leaves.
  assign leaf      = oob_q || (rd_q == '0);
  assign new_ent   = leaf ? root_ent : rd_q;
  assign cnt_dec   = cnt_q - 3'd1;
  assign rd_ent    = cmd_i.first_rd ? eff_ent : new_ent;
  assign rd_bit    = cmd_i.first_rd ? byte_q[cnt_q] : byte_q[cnt_dec];
  assign rd_idx    = rd_bit ? rd_ent[IDX_W-1:0] : rd_ent[ENT_W-1:IDX_W];
  assign rd_en     = cmd_i.first_rd || (cmd_i.step && (cnt_q != 3'd0));
  assign leaf_sym  = SYM_W'(next_q - 9'd1);
  assign out_free  = !out_valid_q || out_ready_i;
  assign load_ok   = cmd_i.load && (32'(in_node_index_i) < 32'(NODE_COUNT));
  assign load_ent  = {in_left_child_i, in_right_child_i};
  assign start_idx = (in_kind_i == KIND_FINAL && tail_q != '0)
                     ? 3'(tail_q - 3'd1) : 3'd7;
  assign push_mid  = cmd_i.step && leaf && pend_valid_q;
  assign push_end  = cmd_i.finish && pend_valid_q;

  assign sts_o.leaf       = leaf;
  assign sts_o.last_bit   = (cnt_q == 3'd0);
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_symbol_o      = out_sym_q;
  assign out_last_of_run_o = out_last_q;

  // Node table: one write port for loads, one registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      node_mem[AW'(in_node_index_i)] <= load_ent;
    end
    if (rd_en) begin
      rd_q <= node_mem[AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      next_q <= rd_idx;
      oob_q  <= !(32'(rd_idx) < 32'(NODE_COUNT));
    end
    if (cmd_i.start) begin
      byte_q  <= in_data_byte_i;
      final_q <= (in_kind_i == KIND_FINAL);
      cnt_q   <= start_idx;
    end else if (cmd_i.step && (cnt_q != 3'd0)) begin
      cnt_q <= cnt_dec;
    end
    // Root entry is shadowed so a leaf can restart the walk without a read.
    if (load_ok && in_node_index_i == ROOT_NODE) begin
      root_q <= load_ent;
    end
    if (load_ok && !at_root_q && in_node_index_i == cur_q) begin
      ent_q <= load_ent;
    end else if (cmd_i.step && !leaf) begin
      ent_q <= rd_q;
      cur_q <= next_q;
    end
    if (cmd_i.step && leaf) begin
      pend_sym_q <= leaf_sym;
    end
    if (push_mid || push_end) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= push_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q       <= '0;
      at_root_q    <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tail_q <= cfg_wdata_i;
      end
      if (cmd_i.step) begin
        at_root_q <= leaf;
      end else if (cmd_i.finish && final_q) begin
        at_root_q <= 1'b1;
      end
      if (cmd_i.step && leaf) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || push_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/huffman_tree_walk_decoder.sv =====
// Huffman tree-walk decoder: top level joining controller and datapath.
//
// Input channel (in_if): one word per handshake. kind LOAD writes node
// node_index with its left/right children into the node table; kind DATA
// decodes all eight bits of data_byte, MSB first; kind FINAL decodes only
// the low tail_bits bits (0 means all eight) and then returns the walk to
// the root. Kind 3 is dropped. Output channel (out_if): one word per
// decoded symbol, with last_of_run set on the final symbol of a byte.
// cfg_we_i/cfg_wdata_i write tail_bits; write it only while idle.
//
// A load word leaves the input ready, so loads can follow back to back. A
// data word is accepted and then blocks the input while the first table
// read is issued, while the walk reads one child per bit (each child lookup
// depends on the previous read) and while the held symbol is released.
// Each symbol is held until the next leaf or the close of its byte, so
// last_of_run is known when sent. If the receiver stalls, the output
// register holds its word and the walk stops at a leaf while a symbol is
// still held. A new word may be accepted while the last output word waits.
// Reset puts the walk at root node 511 and tail_bits at 0; the node table
// is not cleared.
module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  htwd_in_if.sink           in_if,
  htwd_out_if.source        out_if,
  input  logic              cfg_we_i,
  input  logic [TAIL_W-1:0] cfg_wdata_i
);

  htwd_cmd_t cmd;
  htwd_sts_t sts;

  htwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.kind),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htwd_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_kind_i         (in_if.kind),
    .in_node_index_i   (in_if.node_index),
    .in_left_child_i   (in_if.left_child),
    .in_right_child_i  (in_if.right_child),
    .in_data_byte_i    (in_if.data_byte),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .out_symbol_o      (out_if.symbol),
    .out_last_of_run_o (out_if.last_of_run)
  );

endmodule

// ===== dv/huffman_tree_walk_decoder_tb.sv =====
// Testbench for the Huffman tree-walk decoder: directed and random word streams, checked per symbol.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_tb;
  import htwd_pkg::*;

  localparam int TABLE_SIZE  = 512;
  // Cycles to wait once nothing is pending: a data word with no symbols can
  // still be walking, so leave a comfortable margin.
  localparam int SETTLE_CYC  = 24;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;

  // Fixed nodes of the hand-built tree used by the directed tests.
  //   root 511: left -> leaf 66 (symbol 65), right -> inner 300
  //   inner 300: left -> leaf 1 (symbol 0), right -> leaf 400 (symbol 143)
  localparam logic [IDX_W-1:0] LEAF_A   = 9'd66;
  localparam logic [IDX_W-1:0] INNER_N  = 9'd300;
  localparam logic [IDX_W-1:0] LEAF_LO  = 9'd1;
  localparam logic [IDX_W-1:0] LEAF_HI  = 9'd400;
  localparam logic [IDX_W-1:0] SPARE_N  = 9'd299;
  localparam logic [IDX_W-1:0] SPARE_N2 = 9'd298;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [BYTE_W-1:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
  } sym_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [TAIL_W-1:0] cfg_wdata;

  htwd_in_if  in_if ();
  htwd_out_if out_if ();

  huffman_tree_walk_decoder #(
    .NODE_COUNT (TABLE_SIZE)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Decoder mirror: node table, walk position and tail setting, updated
  // in acceptance order. Every accepted data word appends its symbols to
  // sym_expected.
  // ---------------------------------------------------------------------
  logic [ENT_W-1:0]  node_tab [TABLE_SIZE];
  logic [IDX_W-1:0]  cur_node;
  logic [TAIL_W-1:0] tail_bits;
  sym_word_t         sym_expected [$];

  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned counted_words;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          tree_inner [TABLE_SIZE];

  task automatic decode_word(input in_word_t w);
    int               nbits;
    logic [ENT_W-1:0] ent;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] dec;
    sym_word_t        run [$];
    if (w.kind == KIND_LOAD) begin
      node_tab[w.node_index] = {w.left_child, w.right_child};
      return;
    end
    if (w.kind == KIND_NONE) return;
    // final word walks only the low tail bits, zero meaning a full byte
    nbits = (w.kind == KIND_FINAL && tail_bits != '0) ? int'(tail_bits) : BYTE_W;
    for (int b = nbits - 1; b >= 0; b--) begin
      ent = node_tab[cur_node];
      nxt = w.data_byte[b] ? ent[IDX_W-1:0] : ent[ENT_W-1:IDX_W];
      // leaf test right after the move; a leaf is an all-zero entry
      if (node_tab[nxt] == '0) begin
        dec = nxt - 1'b1;
        run.push_back('{symbol: dec[SYM_W-1:0], last_of_run: 1'b0});
        cur_node = ROOT_NODE;
      end else begin
        cur_node = nxt;
      end
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) sym_expected.push_back(run[i]);
    // any partial code is dropped at the end of the stream
    if (w.kind == KIND_FINAL) cur_node = ROOT_NODE;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Word builders. Fields that the kind does not use get random values so
  // every input bit toggles.
  // ---------------------------------------------------------------------
  function automatic in_word_t load_word(input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] l,
                                         input logic [IDX_W-1:0] r);
    in_word_t w;
    w.kind        = KIND_LOAD;
    w.node_index  = idx;
    w.left_child  = l;
    w.right_child = r;
    w.data_byte   = BYTE_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t byte_word(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] b);
    in_word_t w;
    w.kind        = kind;
    w.node_index  = IDX_W'($urandom);
    w.left_child  = IDX_W'($urandom);
    w.right_child = IDX_W'($urandom);
    w.data_byte   = b;
    return w;
  endfunction

  // Present one word, with random gaps before it, and hold it until taken.
  // valid stays high on return so a back-to-back word needs no toggle.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= w.kind;
    in_if.node_index  <= w.node_index;
    in_if.left_child  <= w.left_child;
    in_if.right_child <= w.right_child;
    in_if.data_byte   <= w.data_byte;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    decode_word(w);
    if (w.kind != KIND_NONE) counted_words++;
  endtask

  // Stop sending, let every pending symbol drain, then let any word that
  // yields no symbols finish its walk.
  task automatic wait_decoder_idle();
    in_if.valid <= 1'b0;
    while (sym_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_tail(input logic [TAIL_W-1:0] val);
    wait_decoder_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tail_bits = val;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stalls and the per-word comparison.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : sym_check
    sym_word_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sym_expected.size() == 0) begin
        flag_mismatch("symbol word with none pending", int'(out_if.symbol), -1);
      end else begin
        want = sym_expected.pop_front();
        if (out_if.symbol !== want.symbol)
          flag_mismatch("symbol", int'(out_if.symbol), int'(want.symbol));
        if (out_if.last_of_run !== want.last_of_run)
          flag_mismatch("last_of_run", int'(out_if.last_of_run), int'(want.last_of_run));
      end
    end
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hang detection: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[huffman_tree_walk_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-built tree, all-zero / all-one bytes, mixed codes, extreme indices.
  // The RTL table powers up undefined, so every node a walk can reach is
  // written first, leaves as zero entries.
  task automatic test_basic_walk();
    send_word(load_word(LEAF_A, '0, '0));
    send_word(load_word(LEAF_LO, '0, '0));
    send_word(load_word(LEAF_HI, '0, '0));
    send_word(load_word(ROOT_NODE, LEAF_A, INNER_N));
    send_word(load_word(INNER_N, LEAF_LO, LEAF_HI));
    send_word(load_word('0, '0, '0));
    send_word(load_word(SPARE_N, ROOT_NODE, ROOT_NODE));
    send_word(byte_word(KIND_DATA, 8'h00));   // eight short codes
    send_word(byte_word(KIND_DATA, 8'hFF));   // four two-bit codes
    send_word(byte_word(KIND_DATA, 8'h5A));
  endtask

  // A code that spans two bytes, with an unrelated load in the middle that
  // must not disturb the walk position.
  task automatic test_mid_code_load();
    send_word(byte_word(KIND_DATA, 8'h01));   // ends parked on the inner node
    send_word(load_word(SPARE_N2, '0, ROOT_NODE));
    send_word(byte_word(KIND_DATA, 8'h7F));
    send_word(byte_word(KIND_FINAL, 8'h80));  // tail 0: whole byte walked
  endtask

  // Partial final bytes: high bits ignored, a trailing half code dropped,
  // and the walk back at the root for the following word.
  task automatic test_tail_bits();
    write_tail(3'd3);
    send_word(byte_word(KIND_FINAL, 8'hE5));
    write_tail(3'd7);
    send_word(byte_word(KIND_FINAL, 8'h80));
    write_tail(3'd1);
    send_word(byte_word(KIND_FINAL, 8'h01));  // half a code, no symbol
    send_word(byte_word(KIND_DATA, 8'h00));
    write_tail(3'd0);
  endtask

  // Leaf reached through a zero child (index 0), a self loop that never
  // hits a leaf, and a root that is itself a leaf.
  task automatic test_odd_leaves();
    send_word(load_word(INNER_N, '0, LEAF_HI));
    send_word(byte_word(KIND_DATA, 8'h9F));
    send_word(load_word(INNER_N, INNER_N, INNER_N));
    send_word(byte_word(KIND_DATA, 8'hC3));   // stuck in the loop
    send_word(byte_word(KIND_FINAL, 8'hFF));  // still stuck, then back to root
    send_word(load_word(ROOT_NODE, '0, '0));
    send_word(byte_word(KIND_DATA, BYTE_W'($urandom)));  // eight symbols
  endtask

  // Kind 3 words must neither write the table nor produce symbols.
  task automatic test_unused_kind();
    in_word_t w;
    send_word(load_word(ROOT_NODE, LEAF_A, INNER_N));
    w = byte_word(KIND_NONE, 8'hFF);
    w.node_index  = ROOT_NODE;
    w.left_child  = '0;
    w.right_child = '0;
    send_word(w);
    send_word(byte_word(KIND_DATA, 8'h00));
    send_word(byte_word(KIND_NONE, BYTE_W'($urandom)));
  endtask

  // Random full binary tree rooted at 511. Inner nodes come from 257..510,
  // leaves mostly from 1..256 with some at 0 and above 256, chosen among
  // entries that are still leaves in the table. Leaves are written as zero
  // entries before the inner nodes so every reachable node is defined.
  task automatic build_random_tree(input int unsigned n_leaves);
    logic [IDX_W-1:0] inner_ids [$];
    logic [IDX_W-1:0] kids [$];
    int unsigned      open_slots [$];
    int unsigned      base, stride, pick, slot, tries;
    logic [IDX_W-1:0] cand;
    foreach (tree_inner[i]) tree_inner[i] = 1'b0;
    // odd stride coprime to 254 walks distinct inner indices
    base = $urandom_range(253);
    do stride = 2 * $urandom_range(126) + 1; while (stride == 127);
    inner_ids.push_back(ROOT_NODE);
    tree_inner[ROOT_NODE] = 1'b1;
    kids.push_back('0);
    kids.push_back('0);
    open_slots.push_back(0);
    open_slots.push_back(1);
    // kids[2p] / kids[2p+1] are the children of inner_ids[p]
    while (inner_ids.size() < n_leaves - 1) begin
      pick = $urandom_range(open_slots.size() - 1);
      slot = open_slots[pick];
      open_slots.delete(pick);
      cand = IDX_W'(257 + (base + stride * (inner_ids.size() - 1)) % 254);
      tree_inner[cand] = 1'b1;
      kids[slot] = cand;
      open_slots.push_back(kids.size());
      open_slots.push_back(kids.size() + 1);
      kids.push_back('0);
      kids.push_back('0);
      inner_ids.push_back(cand);
    end
    foreach (open_slots[j]) begin
      tries = 0;
      do begin
        case ($urandom_range(15))
          0:       cand = '0;
          1, 2:    cand = IDX_W'($urandom_range(510, 257));
          default: cand = IDX_W'($urandom_range(256, 1));
        endcase
        tries++;
      end while ((node_tab[cand] != '0 || tree_inner[cand]) && tries < 20);
      kids[open_slots[j]] = cand;
    end
    foreach (open_slots[j]) send_word(load_word(kids[open_slots[j]], '0, '0));
    foreach (inner_ids[p]) send_word(load_word(inner_ids[p], kids[2*p], kids[2*p+1]));
  endtask

  // One stream: fresh tree, random data bytes, usually closed by a final
  // byte. A few stray words (kind 3, random leaf loads) and full drains
  // mixed in.
  task automatic decode_random_stream();
    int unsigned n_leaves, n_bytes;
    n_leaves = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 2);
    build_random_tree(n_leaves);
    n_bytes = $urandom_range(10, 1);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1) == 0)
          send_word(byte_word(KIND_NONE, BYTE_W'($urandom)));
        else
          send_word(load_word(IDX_W'($urandom), '0, '0));
      end
      if ($urandom_range(99) < 3) wait_decoder_idle();
      send_word(byte_word(KIND_DATA, BYTE_W'($urandom)));
    end
    if ($urandom_range(9) != 0) send_word(byte_word(KIND_FINAL, BYTE_W'($urandom)));
  endtask

  task automatic test_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input logic [TAIL_W-1:0] tail, input int unsigned n_words);
    int unsigned stop_at;
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    write_tail(tail);
    stop_at = counted_words + n_words;
    while (counted_words < stop_at) begin
      if ($urandom_range(3) == 0) write_tail(TAIL_W'($urandom));
      decode_random_stream();
    end
  endtask

  initial begin
    foreach (node_tab[i]) node_tab[i] = '0;
    cur_node       = ROOT_NODE;
    tail_bits      = '0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    counted_words  = 0;
    mismatch_count = 0;

    in_if.valid       <= 1'b0;
    in_if.kind        <= KIND_NONE;
    in_if.node_index  <= '0;
    in_if.left_child  <= '0;
    in_if.right_child <= '0;
    in_if.data_byte   <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct    = 19;
    sink_stall_pct = 73;
    test_basic_walk();
    test_mid_code_load();
    test_tail_bits();
    test_odd_leaves();
    test_unused_kind();

    // sender dense / receiver busy, then the reverse, then full rate
    test_random_phase(19, 73, 3'd7, 150);
    test_random_phase(73, 19, 3'd0, 150);
    test_random_phase(0, 0, TAIL_W'($urandom), 150);

    wait_decoder_idle();
    if (mismatch_count == 0) begin
      $display("[huffman_tree_walk_decoder] OK");
    end else begin
      $display("[huffman_tree_walk_decoder] ERROR");
    end
    $finish;
  end

endmodule
